@@ design/isqrt_pkg.sv @@
`default_nettype none

package isqrt_pkg;

  // Operand and result widths.
  localparam int DATA_W = 32;
  localparam int ROOT_W = 16;
  localparam int HALF_W = DATA_W / 2;

  // The normalization stops once the upper half of the shifted value reaches this.
  localparam logic [HALF_W-1:0] NORM_THRESHOLD = 16'h4000;

  // Positive operands up to this value have a root of one.
  localparam logic [DATA_W-1:0] SMALL_LIMIT = 32'd3;

  // Upper bound on the number of Newton divisions for one operand.
  localparam int ITER_W = 7;
  localparam logic [ITER_W-1:0] MAX_DIVS = 7'd65;

  // Normalization shift counter and divider bit counter.
  localparam int SHIFT_W   = 5;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  // Result select codes.
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_ONE  = 2'd1;
  localparam logic [1:0] RES_XN   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       norm_shift;
    logic       init_est;
    logic       div_start;
    logic       step;
    logic       next_iter;
    logic       out_load;
    logic [1:0] res_sel;
  } isqrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nonpos;
    logic small_val;
    logic norm_done;
    logic div_done;
    logic converged;
  } isqrt_sts_t;

endpackage

`default_nettype wire

@@ design/isqrt_if.sv @@
`default_nettype none

interface isqrt_in_if import isqrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface isqrt_out_if import isqrt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

@@ design/isqrt_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module isqrt_div import isqrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    dvs_r, dvs_nxt;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      trial_sub;
  logic                 ge;

  assign trial     = {rem_r, quo_r[DATA_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign ge        = (trial >= {1'b0, dvs_r});
  assign done      = busy_r && (cnt_r == DIV_CNT_W'(DATA_W - 1));
  assign quotient  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

@@ design/isqrt_dp.sv @@
`default_nettype none

// Datapath: operand, normalization shifter, Newton estimates and result register.
module isqrt_dp import isqrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [DATA_W-1:0] in_value,
  input  isqrt_cmd_t        cmd,
  output isqrt_sts_t        sts,
  output logic [ROOT_W-1:0] root
);

  logic [DATA_W-1:0]  v_r, v_nxt;
  logic [DATA_W-1:0]  t_r, t_nxt;
  logic [SHIFT_W-1:0] c_r, c_nxt;
  logic [DATA_W-1:0]  x_r, x_nxt;
  logic [DATA_W-1:0]  xn_r, xn_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;

  logic [SHIFT_W-1:0] init_sh;
  logic [DATA_W-1:0]  v_sh;
  logic [DATA_W:0]    sum;
  logic [DATA_W:0]    delta;
  logic [DATA_W-1:0]  quotient;
  logic               div_done;

  isqrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (v_r),
    .divisor  (x_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // First estimate: shift by half the normalization count plus one, keep the upper half.
  assign init_sh = {1'b0, c_r[SHIFT_W-1:1]} + SHIFT_W'(1);
  assign v_sh    = v_r << init_sh;
  assign sum     = {1'b0, x_r} + {1'b0, quotient};
  assign delta   = {1'b0, xn_r} - {1'b0, x_r};

  assign sts.nonpos    = v_r[DATA_W-1] || (v_r == '0);
  assign sts.small_val = (v_r <= SMALL_LIMIT);
  assign sts.norm_done = (t_r[DATA_W-1:HALF_W] >= NORM_THRESHOLD);
  assign sts.div_done  = div_done;
  assign sts.converged = (delta == '0) || (delta == (DATA_W+1)'(1)) || (delta == '1);

  assign root = root_r;

  always_comb begin
    v_nxt    = v_r;
    t_nxt    = t_r;
    c_nxt    = c_r;
    x_nxt    = x_r;
    xn_nxt   = xn_r;
    root_nxt = root_r;
    if (cmd.load) begin
      v_nxt = in_value;
      t_nxt = in_value;
      c_nxt = '0;
    end
    if (cmd.norm_shift) begin
      t_nxt = {t_r[DATA_W-2:0], 1'b0};
      c_nxt = c_r + 1'b1;
    end
    if (cmd.init_est) begin
      x_nxt = {{(DATA_W-HALF_W){1'b0}}, v_sh[DATA_W-1:HALF_W]};
    end
    if (cmd.step) begin
      // A zero divisor cannot arise here; it is still mapped to an estimate of one.
      xn_nxt = (x_r == '0) ? DATA_W'(1) : sum[DATA_W:1];
    end
    if (cmd.next_iter) begin
      x_nxt = xn_r;
    end
    if (cmd.out_load) begin
      unique case (cmd.res_sel)
        RES_ZERO: root_nxt = '0;
        RES_ONE:  root_nxt = ROOT_W'(1);
        RES_XN:   root_nxt = xn_r[ROOT_W-1:0];
        default:  root_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    t_r    <= t_nxt;
    c_r    <= c_nxt;
    x_r    <= x_nxt;
    xn_r   <= xn_nxt;
    root_r <= root_nxt;
  end

endmodule

`default_nettype wire

@@ design/isqrt_ctrl.sv @@
`default_nettype none

// Sequencer for one square root: classify, normalize, iterate, deliver.
module isqrt_ctrl import isqrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  isqrt_sts_t sts,
  output isqrt_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLASS  = 4'd1;
  localparam logic [3:0] S_NORM   = 4'd2;
  localparam logic [3:0] S_INIT   = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_STEP   = 4'd6;
  localparam logic [3:0] S_CHECK  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [1:0]        res_sel_r, res_sel_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = '0;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        priority if (sts.nonpos) begin
          res_sel_nxt = RES_ZERO;
          state_nxt   = S_FIN;
        end else if (sts.small_val) begin
          res_sel_nxt = RES_ONE;
          state_nxt   = S_FIN;
        end else begin
          res_sel_nxt = RES_XN;
          state_nxt   = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          state_nxt = S_INIT;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      S_INIT: begin
        cmd.init_est = 1'b1;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        iter_nxt  = iter_r + 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.converged || (iter_r == MAX_DIVS)) begin
          state_nxt = S_FIN;
        end else begin
          cmd.next_iter = 1'b1;
          state_nxt     = S_DSTART;
        end
      end
      S_FIN: begin
        cmd.res_sel = res_sel_r;
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iter_r      <= '0;
      res_sel_r   <= RES_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/newton_integer_square_root_top.sv @@
// Channel   Role    Payload                  Transfer
// in_ch     sink    value [31:0], signed     valid && ready
// out_ch    source  root  [15:0], unsigned   valid && ready
//
// One operand is processed at a time. Zero, negative operands and 1 to 3 go from
// classification straight to the loaded result; larger operands are first normalized
// by up to 28 left shifts, one bit per cycle, then run Newton divisions, each through
// the divider and the step and check states, until the estimates converge or hit the limit.
// Reset is synchronous and active low and clears the controller and divider.
// A waiting result does not hold off the next input transaction, only the next delivery.
`default_nettype none

module newton_integer_square_root_top import isqrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  isqrt_in_if.sink    in_ch,
  isqrt_out_if.source out_ch
);

  isqrt_cmd_t cmd;
  isqrt_sts_t sts;

  // The controller sequences classification, normalization, the Newton loop
  // and the hand-off to the output register.
  isqrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the operand, the estimates, the divider and the
  // result register that drives the output payload.
  isqrt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .sts      (sts),
    .root     (out_ch.root)
  );

`ifndef ASSERT_OFF
  // In the cycle after an input transaction the block is busy and not ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // The first estimate is formed only after normalization has finished.
  a_init_after_norm: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init_est |-> $past(sts.norm_done))
    else $error("estimate formed before normalization finished");

  // Every delivered root lies within the range of a 31-bit operand.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.root <= 16'd46341))
    else $error("root out of range");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
  import isqrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run length and pacing. The block works on one operand at a time, so even
  // the idle-heavy phases finish far inside the cycle limit.
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES  = 400;
  localparam int HOLD_CYCLES   = 3000;
  localparam int RANDOM_PHASE0 = 330;
  localparam int RANDOM_PHASE1 = 330;
  localparam int RANDOM_PHASE2 = 340;

  // One expected result, kept with the operand that caused it so that a
  // mismatch line can say which operand went wrong.
  typedef struct {
    logic [DATA_W-1:0] operand;
    logic [ROOT_W-1:0] root;
  } root_due_t;

  logic clk = 1'b0;
  logic rst_n;

  isqrt_in_if  in_ch ();
  isqrt_out_if out_ch ();

  newton_integer_square_root_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Operands that wait for the driver, and roots that wait for the block.
  logic [DATA_W-1:0] operands_pending[$];
  root_due_t         roots_due[$];

  int src_idle_pct;
  int snk_idle_pct;
  int phase;
  int hold_left;
  bit hold_done;
  int err_cnt;
  int cycle_cnt;
  root_due_t oldest;

  // Each mismatch gives one line and is counted. The run goes on after it.
  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
  endtask

  // One Newton step, x' = (x + v / x) >> 1. The sum is kept at 33 bits so it
  // cannot wrap. A zero estimate cannot happen for operands of 4 and up. It is
  // still guarded, and then the next estimate is 1.
  function automatic logic [DATA_W-1:0] newton_next(input logic [DATA_W-1:0] operand,
                                                    input logic [DATA_W-1:0] est);
    logic [DATA_W:0] sum;
    if (est == '0) begin
      return 1;
    end
    sum = {1'b0, est} + {1'b0, operand / est};
    return sum[DATA_W:1];
  endfunction

  // Expected root of one operand. The operand is read as a signed value:
  // zero and negative values give 0, and 1 to 3 give 1. Larger values start
  // from a normalized estimate. Newton steps then run until two estimates
  // are within one of each other. The step count is bounded.
  function automatic logic [ROOT_W-1:0] root_of(input logic [DATA_W-1:0] operand);
    logic [DATA_W-1:0] norm;
    logic [DATA_W-1:0] est;
    logic [DATA_W-1:0] nxt;
    logic [DATA_W-1:0] gap;
    int                shift;
    int                k;
    if (operand[DATA_W-1] || operand == '0) begin
      return '0;
    end
    if (operand <= SMALL_LIMIT) begin
      return 16'd1;
    end
    // Count the left shifts that lift the upper half to the threshold.
    norm  = operand;
    shift = 0;
    while (norm[DATA_W-1:HALF_W] < NORM_THRESHOLD && shift < DATA_W) begin
      norm  = norm << 1;
      shift = shift + 1;
    end
    shift = (shift >> 1) + 1;
    if (shift > DATA_W - 1) begin
      shift = DATA_W - 1;
    end
    norm = operand << shift;
    est  = {{HALF_W{1'b0}}, norm[DATA_W-1:HALF_W]};
    nxt  = newton_next(operand, est);
    for (k = 0; k < 64; k++) begin
      gap = (nxt > est) ? nxt - est : est - nxt;
      if (gap <= 1) begin
        break;
      end
      est = nxt;
      nxt = newton_next(operand, est);
    end
    return nxt[ROOT_W-1:0];
  endfunction

  // Random operands. Fully random words cover every bit, and half of them
  // are negative. Most of the rest are positive values spread over all
  // magnitudes, so that the normalization count and the number of Newton
  // steps vary widely. The remainder are tiny values and values next to
  // perfect squares, where an estimate that is off by one would show.
  task automatic queue_random_operands(input int count);
    int                n;
    int unsigned       r;
    logic [DATA_W-1:0] v;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1: begin
          v = $urandom;
        end
        2: begin
          v = $urandom_range(16);
        end
        3: begin
          r = $urandom_range(46340, 2);
          v = r * r + $urandom_range(2) - 1;
        end
        default: begin
          v = $urandom >> $urandom_range(31, 1);
        end
      endcase
      operands_pending.push_back(v);
    end
  endtask

  // The driver presents the next operand whenever the input channel is free.
  // It idles at random at the current sender rate. Accepted operands are
  // turned into expected roots at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        roots_due.push_back('{operand: in_ch.value, root: root_of(in_ch.value)});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (operands_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.value <= operands_pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off is counted here, on its own. It starts once,
  // at the start of the phase in which nobody idles. The sender keeps
  // offering operands the whole time. So the block fills its output register
  // and its working slot, and then must hold off the input channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase == 2 && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The monitor compares every root transaction with the oldest expected
  // root. Then it picks the next value of ready from the receiver rate, or
  // keeps ready low during the hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (roots_due.size() == 0) begin
          report_mismatch($sformatf("root %0d arrived with nothing expected", out_ch.root));
        end else begin
          oldest = roots_due.pop_front();
          if (out_ch.root !== oldest.root) begin
            report_mismatch($sformatf("value %0d (0x%08h): root %0d, expected %0d",
                                      $signed(oldest.operand), oldest.operand,
                                      out_ch.root, oldest.root));
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d roots outstanding",
               cycle_cnt, roots_due.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    // Every input of the block is known from time zero on. Reset is held low
    // from time zero and released once.
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    phase        = 0;
    src_idle_pct = 36;
    snk_idle_pct = 79;

    // Directed operands: zero, the smallest values that take the early exits,
    // the first value that needs Newton steps, powers of two around the
    // normalization boundaries, perfect squares and their neighbors, the
    // largest positive value and the most negative ones.
    operands_pending.push_back(32'h0000_0000);
    operands_pending.push_back(32'h0000_0001);
    operands_pending.push_back(32'h0000_0002);
    operands_pending.push_back(32'h0000_0003);
    operands_pending.push_back(32'h0000_0004);
    operands_pending.push_back(32'h0000_0005);
    operands_pending.push_back(32'h0000_0008);
    operands_pending.push_back(32'h0000_0009);
    operands_pending.push_back(32'h0000_000F);
    operands_pending.push_back(32'h0000_0010);
    operands_pending.push_back(32'h0000_0011);
    operands_pending.push_back(32'h0000_00FF);
    operands_pending.push_back(32'h0000_FFFF);
    operands_pending.push_back(32'h0001_0000);
    operands_pending.push_back(32'h3FFF_FFFF);
    operands_pending.push_back(32'h4000_0000);
    operands_pending.push_back(32'd2147395599);
    operands_pending.push_back(32'd2147395600);
    operands_pending.push_back(32'h7FFF_FFFF);
    operands_pending.push_back(32'h5555_5555);
    operands_pending.push_back(32'hAAAA_AAAA);
    operands_pending.push_back(32'hFFFF_FFFF);
    operands_pending.push_back(32'h8000_0000);
    operands_pending.push_back(32'h8000_0001);
    queue_random_operands(RANDOM_PHASE0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // The sender idles less than the receiver. Each phase change waits until
    // the driver has run out of operands.
    while (operands_pending.size() != 0) @(posedge clk);

    // The other way round: the sender idles more and the receiver less.
    queue_random_operands(RANDOM_PHASE1);
    src_idle_pct <= 79;
    snk_idle_pct <= 36;
    while (operands_pending.size() != 0) @(posedge clk);

    // Neither side idles, apart from the long receiver hold-off at the start.
    queue_random_operands(RANDOM_PHASE2);
    src_idle_pct <= 0;
    snk_idle_pct <= 0;
    phase        <= 2;
    while (operands_pending.size() != 0) @(posedge clk);

    // Wait for the last roots. Then give the block time to show any
    // surplus transaction.
    while (roots_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/isqrt_pkg.sv
design/isqrt_if.sv
design/isqrt_div.sv
design/isqrt_dp.sv
design/isqrt_ctrl.sv
design/newton_integer_square_root_top.sv
tb/sv/tb_top.sv
